FILE: hw/rtl/tgc_pkg.sv
package tgc_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 10;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 16;
    localparam int LCD_W   = 12;
    localparam int SPAN_W  = 16;
    localparam int THR_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Rounded scale: numerator raw*lcd + span/2 fits in 28 bits, held in an even width of 30.
    localparam int NUM_W     = 30;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [TYPE_W-1:0] EVT_KEY = 5'd1;
    localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;
    localparam logic [CODE_W-1:0] CODE_X     = 10'd0;
    localparam logic [CODE_W-1:0] CODE_Y     = 10'd1;
    localparam logic [CODE_W-1:0] CODE_TOUCH = 10'd330;
    localparam logic [VALUE_W-1:0] KEY_PRESS   = 16'd1;
    localparam logic [VALUE_W-1:0] KEY_RELEASE = 16'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_W    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_H    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_THR  = 3'd5;

    localparam logic              RST_SCALE_EN = 1'b1;
    localparam logic [LCD_W-1:0]  RST_SCR_W    = 12'd800;
    localparam logic [LCD_W-1:0]  RST_SCR_H    = 12'd480;
    localparam logic [SPAN_W-1:0] RST_SPAN_X   = 16'd1024;
    localparam logic [SPAN_W-1:0] RST_SPAN_Y   = 16'd600;
    localparam logic [THR_W-1:0]  RST_TAP_THR  = 16'd30;

    typedef enum logic [2:0] {
        G_NONE  = 3'd0,
        G_TAP   = 3'd1,
        G_UP    = 3'd2,
        G_DOWN  = 3'd3,
        G_LEFT  = 3'd4,
        G_RIGHT = 3'd5
    } t_gesture;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic latch_raw;
        logic key_update;
        logic mul_load;
        logic div_step;
        logic store_axis;
        logic axis_y;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_abs;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/tgc_ctrl.sv
module tgc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tgc_pkg::t_dp_sts i_sts,
    output tgc_pkg::t_dp_cmd o_cmd
);

    tgc_pkg::t_state r_state, n_state;
    logic            r_axis_y, n_axis_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tgc_pkg::S_IDLE;
            r_axis_y <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_axis_y <= n_axis_y;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis_y   = r_axis_y;
        o_cmd      = '0;
        o_cmd.axis_y = r_axis_y;
        o_in_ready = 1'b0;
        unique case (r_state)
            tgc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = tgc_pkg::S_DECODE;
                end
            end
            tgc_pkg::S_DECODE: begin
                if (i_sts.is_abs) begin
                    o_cmd.latch_raw = 1'b1;
                    n_axis_y = 1'b0;
                    n_state  = tgc_pkg::S_MUL;
                end else begin
                    o_cmd.key_update = 1'b1;
                    n_state = tgc_pkg::S_OUT;
                end
            end
            tgc_pkg::S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state = tgc_pkg::S_DIV;
            end
            tgc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = tgc_pkg::S_STORE;
                end
            end
            tgc_pkg::S_STORE: begin
                o_cmd.store_axis = 1'b1;
                if (r_axis_y) begin
                    n_state = tgc_pkg::S_OUT;
                end else begin
                    n_axis_y = 1'b1;
                    n_state  = tgc_pkg::S_MUL;
                end
            end
            tgc_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = tgc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tgc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/tgc_dp.sv
module tgc_dp #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tgc_pkg::t_dp_cmd               i_cmd,
    output tgc_pkg::t_dp_sts               o_sts,
    input  logic [tgc_pkg::TYPE_W-1:0]     i_evt_type,
    input  logic [tgc_pkg::CODE_W-1:0]     i_evt_code,
    input  logic [tgc_pkg::VALUE_W-1:0]    i_evt_value,
    input  logic                           i_cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tgc_pkg::POS_W-1:0]      o_pos_x,
    output logic [tgc_pkg::POS_W-1:0]      o_pos_y,
    output tgc_pkg::t_gesture              o_gesture
);

    localparam int WIDE_W = 34;
    localparam int DIFF_W = COORD_BITS + 2;
    localparam logic [WIDE_W-1:0] LIM_WIDE = (WIDE_W'(1) << COORD_BITS) - WIDE_W'(1);
    localparam logic [COORD_BITS-1:0] LIM = COORD_BITS'(LIM_WIDE);

    logic                           r_scale_en;
    logic [tgc_pkg::LCD_W-1:0]      r_scr_w, r_scr_h;
    logic [tgc_pkg::SPAN_W-1:0]     r_span_x, r_span_y;
    logic [tgc_pkg::THR_W-1:0]      r_tap_thr;

    logic [tgc_pkg::TYPE_W-1:0]     r_evt_type;
    logic [tgc_pkg::CODE_W-1:0]     r_evt_code;
    logic [tgc_pkg::VALUE_W-1:0]    r_evt_value;

    logic [tgc_pkg::VALUE_W-1:0]    r_raw_x, r_raw_y;
    logic [COORD_BITS-1:0]          r_cur_x, r_cur_y, r_start_x, r_start_y;
    logic                           r_press_seen;
    tgc_pkg::t_gesture              r_gesture;

    logic [tgc_pkg::NUM_W-1:0]      r_dq, n_dq;
    logic [tgc_pkg::SPAN_W-1:0]     r_rem, n_rem;
    logic [tgc_pkg::SPAN_W-1:0]     r_span;
    logic [tgc_pkg::DIV_CNT_W-1:0]  r_div_cnt;

    logic                           r_out_valid;
    logic [tgc_pkg::POS_W-1:0]      r_out_x, r_out_y;
    tgc_pkg::t_gesture              r_out_g;

    logic                           is_touch;
    logic [tgc_pkg::VALUE_W-1:0]    mul_raw;
    logic [tgc_pkg::LCD_W-1:0]      mul_lcd;
    logic [tgc_pkg::SPAN_W-1:0]     mul_span;
    logic [tgc_pkg::NUM_W-1:0]      mul_num;

    logic [tgc_pkg::SPAN_W:0]       rem_a, rem_b;
    logic                           ge_a, ge_b;
    logic [tgc_pkg::SPAN_W-1:0]     rem_a_sub;

    logic [WIDE_W-1:0]              raw_wide;
    logic [COORD_BITS-1:0]          map_val;

    logic [DIFF_W-1:0]              start_sx, start_sy;
    logic signed [DIFF_W-1:0]       dx, dy;
    logic [DIFF_W-1:0]              ax, ay;
    logic                           is_tap;
    tgc_pkg::t_gesture              rel_gesture;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_en <= tgc_pkg::RST_SCALE_EN;
            r_scr_w    <= tgc_pkg::RST_SCR_W;
            r_scr_h    <= tgc_pkg::RST_SCR_H;
            r_span_x   <= tgc_pkg::RST_SPAN_X;
            r_span_y   <= tgc_pkg::RST_SPAN_Y;
            r_tap_thr  <= tgc_pkg::RST_TAP_THR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tgc_pkg::CFG_SCALE_EN: r_scale_en <= i_cfg_data[0];
                tgc_pkg::CFG_SCR_W:    r_scr_w    <= i_cfg_data[tgc_pkg::LCD_W-1:0];
                tgc_pkg::CFG_SCR_H:    r_scr_h    <= i_cfg_data[tgc_pkg::LCD_W-1:0];
                tgc_pkg::CFG_SPAN_X:   r_span_x   <= i_cfg_data;
                tgc_pkg::CFG_SPAN_Y:   r_span_y   <= i_cfg_data;
                tgc_pkg::CFG_TAP_THR:  r_tap_thr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign is_touch = (r_evt_type == tgc_pkg::EVT_KEY) && (r_evt_code == tgc_pkg::CODE_TOUCH);

    assign mul_raw  = i_cmd.axis_y ? r_raw_y  : r_raw_x;
    assign mul_lcd  = i_cmd.axis_y ? r_scr_h  : r_scr_w;
    assign mul_span = i_cmd.axis_y ? r_span_y : r_span_x;
    assign mul_num  = tgc_pkg::NUM_W'(mul_raw * mul_lcd)
                    + tgc_pkg::NUM_W'(mul_span >> 1);

    // Two restoring division steps per cycle.
    always_comb begin
        rem_a     = {r_rem, r_dq[tgc_pkg::NUM_W-1]};
        ge_a      = rem_a >= {1'b0, r_span};
        rem_a_sub = ge_a ? tgc_pkg::SPAN_W'(rem_a - {1'b0, r_span})
                         : rem_a[tgc_pkg::SPAN_W-1:0];
        rem_b     = {rem_a_sub, r_dq[tgc_pkg::NUM_W-2]};
        ge_b      = rem_b >= {1'b0, r_span};
        n_rem     = ge_b ? tgc_pkg::SPAN_W'(rem_b - {1'b0, r_span})
                         : rem_b[tgc_pkg::SPAN_W-1:0];
        n_dq      = {r_dq[tgc_pkg::NUM_W-3:0], ge_a, ge_b};
    end

    always_comb begin
        raw_wide = WIDE_W'(mul_raw) & LIM_WIDE;
        if (!r_scale_en) begin
            map_val = COORD_BITS'(raw_wide);
        end else if (r_span == '0) begin
            map_val = LIM;
        end else if (WIDE_W'(r_dq) > LIM_WIDE) begin
            map_val = LIM;
        end else begin
            map_val = COORD_BITS'(r_dq);
        end
    end

    always_comb begin
        start_sx = r_press_seen ? DIFF_W'(r_start_x) : '1;
        start_sy = r_press_seen ? DIFF_W'(r_start_y) : '1;
        dx = $signed(DIFF_W'(r_cur_x) - start_sx);
        dy = $signed(DIFF_W'(r_cur_y) - start_sy);
        ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        is_tap = (WIDE_W'(ax) < WIDE_W'(r_tap_thr)) && (WIDE_W'(ay) < WIDE_W'(r_tap_thr));
        priority if (is_tap) begin
            rel_gesture = tgc_pkg::G_TAP;
        end else if (ay > ax) begin
            rel_gesture = dy[DIFF_W-1] ? tgc_pkg::G_UP : tgc_pkg::G_DOWN;
        end else begin
            rel_gesture = dx[DIFF_W-1] ? tgc_pkg::G_LEFT : tgc_pkg::G_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_x      <= '0;
            r_raw_y      <= '0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_press_seen <= 1'b0;
            r_div_cnt    <= '0;
            r_gesture    <= tgc_pkg::G_NONE;
        end else begin
            if (i_cmd.capture) begin
                r_gesture <= tgc_pkg::G_NONE;
            end
            if (i_cmd.latch_raw) begin
                if (r_evt_code == tgc_pkg::CODE_X) begin
                    r_raw_x <= r_evt_value;
                end
                if (r_evt_code == tgc_pkg::CODE_Y) begin
                    r_raw_y <= r_evt_value;
                end
            end
            if (i_cmd.key_update && is_touch) begin
                if (r_evt_value == tgc_pkg::KEY_PRESS) begin
                    if (!r_press_seen) begin
                        r_start_x    <= r_cur_x;
                        r_start_y    <= r_cur_y;
                        r_press_seen <= 1'b1;
                    end
                end else if (r_evt_value == tgc_pkg::KEY_RELEASE) begin
                    r_gesture    <= rel_gesture;
                    r_raw_x      <= '0;
                    r_raw_y      <= '0;
                    r_start_x    <= '0;
                    r_start_y    <= '0;
                    r_press_seen <= 1'b0;
                end
            end
            if (i_cmd.mul_load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + tgc_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.store_axis) begin
                if (i_cmd.axis_y) begin
                    r_cur_y <= map_val;
                end else begin
                    r_cur_x <= map_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_evt_type  <= i_evt_type;
            r_evt_code  <= i_evt_code;
            r_evt_value <= i_evt_value;
        end
        if (i_cmd.mul_load) begin
            r_dq   <= mul_num;
            r_rem  <= '0;
            r_span <= mul_span;
        end else if (i_cmd.div_step) begin
            r_dq  <= n_dq;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x <= tgc_pkg::POS_W'(r_cur_x);
            r_out_y <= tgc_pkg::POS_W'(r_cur_y);
            r_out_g <= r_gesture;
        end
    end

    assign o_sts.is_abs   = r_evt_type == tgc_pkg::EVT_ABS;
    assign o_sts.div_last = r_div_cnt == tgc_pkg::DIV_CNT_W'(tgc_pkg::DIV_STEPS - 1);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_gesture   = r_out_g;

endmodule

FILE: hw/rtl/touch_gesture_classifier_unit.sv
// Key and ignored events go through decode and output steps; absolute-axis events also run
// two radix-4 divisions one after the other on a shared divider, each with a multiply step
// before it and a store step after it. A new event is taken in only once the previous one
// has loaded its result. A result held at the output still lets the next event be taken in;
// that event then waits in its output step until the held result moves on.
// Reset (i_rst_n low, synchronous) clears the gesture state and loads the default registers.
module touch_gesture_classifier_unit #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // event_code, event_value
    input  logic [tgc_pkg::TYPE_W-1:0]     s_axis_tuser,  // event_type
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // pos_x, pos_y, gesture
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tgc_pkg::t_dp_cmd            cmd;
    tgc_pkg::t_dp_sts            sts;
    logic [tgc_pkg::POS_W-1:0]   pos_x, pos_y;
    tgc_pkg::t_gesture           gesture;

    assign o_cfg_ready = 1'b1;

    tgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tgc_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_evt_type  (s_axis_tuser),
        .i_evt_code  (s_axis_tdata[9:0]),
        .i_evt_value (s_axis_tdata[25:10]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_pos_x     (pos_x),
        .o_pos_y     (pos_y),
        .o_gesture   (gesture)
    );

    assign m_axis_tdata = {5'd0, gesture, pos_y, pos_x};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tgc_pkg::*;

    typedef struct packed {
        logic [TYPE_W-1:0]  ev_type;
        logic [CODE_W-1:0]  ev_code;
        logic [VALUE_W-1:0] ev_value;
    } touch_event_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        t_gesture         gesture;
    } touch_report_t;

    typedef struct packed {
        touch_event_t  ev;
        logic          known;
        touch_report_t report;
    } directed_row_t;

    typedef struct packed {
        logic              scale;
        logic [LCD_W-1:0]  width;
        logic [LCD_W-1:0]  height;
        logic [SPAN_W-1:0] span_x;
        logic [SPAN_W-1:0] span_y;
        logic [THR_W-1:0]  thr;
    } screen_setup_t;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [TYPE_W-1:0] s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the block's registers and gesture state.
    logic              scale_en   = RST_SCALE_EN;
    logic [LCD_W-1:0]  scr_w      = RST_SCR_W;
    logic [LCD_W-1:0]  scr_h      = RST_SCR_H;
    logic [SPAN_W-1:0] span_x     = RST_SPAN_X;
    logic [SPAN_W-1:0] span_y     = RST_SPAN_Y;
    logic [THR_W-1:0]  tap_thr    = RST_TAP_THR;
    logic [VALUE_W-1:0] raw_x     = '0;
    logic [VALUE_W-1:0] raw_y     = '0;
    logic [POS_W-1:0]  cur_x      = '0;
    logic [POS_W-1:0]  cur_y      = '0;
    logic [POS_W-1:0]  start_x    = '0;
    logic [POS_W-1:0]  start_y    = '0;
    bit                press_seen = 1'b0;

    touch_report_t pending_reports[$];
    directed_row_t directed_rows[$];

    bit no_idle = 1'b0;
    int mismatches = 0;
    int events_sent = 0;
    int events_active = 0;
    int reports_checked = 0;
    int setups_applied = 0;
    int gesture_hits[0:7];

    touch_gesture_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("touch_gesture_classifier_unit test failed");
        $finish;
    end

    function automatic logic [POS_W-1:0] map_coord(logic [VALUE_W-1:0] raw,
                                                   logic [LCD_W-1:0] lcd,
                                                   logic [SPAN_W-1:0] span);
        longint unsigned q;
        if (!scale_en) begin
            return raw;
        end
        if (span == 0) begin
            return POS_MAX;
        end
        q = (64'(raw) * 64'(lcd) + 64'(span >> 1)) / 64'(span);
        return (q > 64'(POS_MAX)) ? POS_MAX : q[POS_W-1:0];
    endfunction

    function automatic touch_report_t classify_event(touch_event_t ev);
        touch_report_t r;
        longint sx, sy, dx, dy, ax, ay;
        r.gesture = G_NONE;
        if (ev.ev_type == EVT_ABS) begin
            if (ev.ev_code == CODE_X) begin
                raw_x = ev.ev_value;
            end
            if (ev.ev_code == CODE_Y) begin
                raw_y = ev.ev_value;
            end
            cur_x = map_coord(raw_x, scr_w, span_x);
            cur_y = map_coord(raw_y, scr_h, span_y);
        end else if (ev.ev_type == EVT_KEY && ev.ev_code == CODE_TOUCH) begin
            if (ev.ev_value == KEY_PRESS) begin
                if (!press_seen) begin
                    start_x = cur_x;
                    start_y = cur_y;
                    press_seen = 1'b1;
                end
            end else if (ev.ev_value == KEY_RELEASE) begin
                // Without a recorded press the start point sits just outside the screen.
                sx = press_seen ? longint'(start_x) : -1;
                sy = press_seen ? longint'(start_y) : -1;
                dx = longint'(cur_x) - sx;
                dy = longint'(cur_y) - sy;
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                if (ax < longint'(tap_thr) && ay < longint'(tap_thr)) begin
                    r.gesture = G_TAP;
                end else if (ay > ax) begin
                    r.gesture = (dy < 0) ? G_UP : G_DOWN;
                end else begin
                    r.gesture = (dx < 0) ? G_LEFT : G_RIGHT;
                end
                raw_x = '0;
                raw_y = '0;
                start_x = '0;
                start_y = '0;
                press_seen = 1'b0;
            end
        end
        r.pos_x = cur_x;
        r.pos_y = cur_y;
        return r;
    endfunction

    function automatic touch_event_t make_event(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                                                logic [VALUE_W-1:0] v);
        touch_event_t ev;
        ev.ev_type = t;
        ev.ev_code = c;
        ev.ev_value = v;
        return ev;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    task automatic send_event(touch_event_t ev, bit known, touch_report_t typed);
        int gap;
        touch_report_t r;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {6'd0, ev.ev_value, ev.ev_code};
        s_axis_tuser  <= ev.ev_type;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        r = classify_event(ev);
        pending_reports.push_back(known ? typed : r);
        events_sent++;
        if (ev.ev_type == EVT_ABS || (ev.ev_type == EVT_KEY && ev.ev_code == CODE_TOUCH &&
                                      ev.ev_value <= 1)) begin
            events_active++;
        end
    endtask

    task automatic send_plain(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c,
                              logic [VALUE_W-1:0] v);
        send_event(make_event(t, c, v), 1'b0, '0);
    endtask

    task automatic add_row(logic [TYPE_W-1:0] t, logic [CODE_W-1:0] c, logic [VALUE_W-1:0] v,
                           logic known, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                           t_gesture g);
        directed_row_t row;
        row.ev = make_event(t, c, v);
        row.known = known;
        row.report.pos_x = x;
        row.report.pos_y = y;
        row.report.gesture = g;
        directed_rows.push_back(row);
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCALE_EN: scale_en = data[0];
            CFG_SCR_W:    scr_w = data[LCD_W-1:0];
            CFG_SCR_H:    scr_h = data[LCD_W-1:0];
            CFG_SPAN_X:   span_x = data;
            CFG_SPAN_Y:   span_y = data;
            CFG_TAP_THR:  tap_thr = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(screen_setup_t s);
        write_reg(CFG_SCALE_EN, 16'(s.scale));
        write_reg(CFG_SCR_W, 16'(s.width));
        write_reg(CFG_SCR_H, 16'(s.height));
        write_reg(CFG_SPAN_X, s.span_x);
        write_reg(CFG_SPAN_Y, s.span_y);
        write_reg(CFG_TAP_THR, s.thr);
        i_cfg_valid <= 1'b0;
        setups_applied++;
    endtask

    function automatic logic [VALUE_W-1:0] next_raw(logic [VALUE_W-1:0] last);
        int v;
        if ($urandom_range(0, 1) == 0) begin
            return VALUE_W'($urandom_range(0, 65535));
        end
        v = int'(last) + $urandom_range(0, 80) - 40;
        if (v < 0) begin
            v = 0;
        end
        if (v > 65535) begin
            v = 65535;
        end
        return VALUE_W'(v);
    endfunction

    task automatic send_move;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            send_plain(EVT_ABS, CODE_X, next_raw(raw_x));
        end else if (pick < 9) begin
            send_plain(EVT_ABS, CODE_Y, next_raw(raw_y));
        end else begin
            send_plain(EVT_ABS, CODE_W'($urandom_range(2, 1023)), VALUE_W'($urandom));
        end
    endtask

    task automatic run_random(int count);
        int target, pick;
        logic [TYPE_W-1:0]  t;
        logic [CODE_W-1:0]  c;
        logic [VALUE_W-1:0] v;
        target = events_active + count;
        while (events_active < target) begin
            if ($urandom_range(0, 29) == 0) begin
                no_idle = !no_idle;
            end
            if ($urandom_range(0, 9) < 7) begin
                // A touch stroke: some moves, usually a press (sometimes repeated), more moves, a release.
                repeat ($urandom_range(0, 2)) send_move();
                if ($urandom_range(0, 7) != 0) begin
                    send_plain(EVT_KEY, CODE_TOUCH, KEY_PRESS);
                end
                if ($urandom_range(0, 4) == 0) begin
                    send_plain(EVT_KEY, CODE_TOUCH, KEY_PRESS);
                end
                repeat ($urandom_range(0, 4)) send_move();
                send_plain(EVT_KEY, CODE_TOUCH, KEY_RELEASE);
            end else begin
                pick = $urandom_range(0, 2);
                t = (pick == 0) ? EVT_ABS : (pick == 1) ? EVT_KEY
                                                        : TYPE_W'($urandom_range(0, 31));
                pick = $urandom_range(0, 3);
                c = (pick == 0) ? CODE_X : (pick == 1) ? CODE_Y
                  : (pick == 2) ? CODE_TOUCH : CODE_W'($urandom_range(0, 1023));
                pick = $urandom_range(0, 2);
                v = (pick == 0) ? KEY_RELEASE : (pick == 1) ? KEY_PRESS
                                                            : VALUE_W'($urandom);
                send_plain(t, c, v);
            end
        end
    endtask

    initial begin
        int stall_left;
        touch_report_t want;
        logic [POS_W-1:0] got_x, got_y;
        logic [2:0] got_g;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got_x = m_axis_tdata[15:0];
                got_y = m_axis_tdata[31:16];
                got_g = m_axis_tdata[34:32];
                if (pending_reports.size() == 0) begin
                    report_mismatch("result transfer with nothing pending, pos_x", got_x, -1);
                end else begin
                    want = pending_reports.pop_front();
                    if (got_x !== want.pos_x) begin
                        report_mismatch("pos_x", got_x, want.pos_x);
                    end
                    if (got_y !== want.pos_y) begin
                        report_mismatch("pos_y", got_y, want.pos_y);
                    end
                    if (got_g !== want.gesture) begin
                        report_mismatch("gesture", got_g, want.gesture);
                    end
                end
                reports_checked++;
                gesture_hits[got_g]++;
                stall_left = no_idle ? 0 : $urandom_range(0, 4);
            end
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    initial begin
        screen_setup_t setups[$];
        screen_setup_t s;
        int directed_count;
        foreach (gesture_hits[i]) gesture_hits[i] = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        add_row(5'd0, 10'd0, 16'd0, 1'b1, 16'd0, 16'd0, G_NONE);
        add_row(5'd31, 10'd1023, 16'hFFFF, 1'b1, 16'd0, 16'd0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, 16'd2, 1'b1, 16'd0, 16'd0, G_NONE);
        add_row(EVT_KEY, CODE_X, KEY_PRESS, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_RELEASE, 1'b1, 16'd0, 16'd0, G_TAP);
        add_row(EVT_ABS, CODE_X, 16'd1024, 1'b1, 16'd800, 16'd0, G_NONE);
        add_row(EVT_ABS, CODE_Y, 16'd600, 1'b1, 16'd800, 16'd480, G_NONE);
        add_row(EVT_ABS, CODE_TOUCH, 16'd77, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_PRESS, 1'b1, 16'd800, 16'd480, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_PRESS, 1'b0, '0, '0, G_NONE);
        add_row(EVT_ABS, CODE_X, 16'd0, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_RELEASE, 1'b1, 16'd0, 16'd480, G_LEFT);
        add_row(EVT_ABS, CODE_X, 16'hFFFF, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_PRESS, 1'b0, '0, '0, G_NONE);
        add_row(EVT_ABS, CODE_Y, 16'hFFFF, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_RELEASE, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_PRESS, 1'b0, '0, '0, G_NONE);
        add_row(EVT_ABS, CODE_Y, 16'd0, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_RELEASE, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_PRESS, 1'b0, '0, '0, G_NONE);
        add_row(EVT_ABS, CODE_X, 16'd100, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, KEY_RELEASE, 1'b0, '0, '0, G_NONE);
        add_row(EVT_KEY, CODE_TOUCH, 16'h8000, 1'b0, '0, '0, G_NONE);

        foreach (directed_rows[i]) begin
            send_event(directed_rows[i].ev, directed_rows[i].known, directed_rows[i].report);
        end
        directed_count = events_sent;
        wait_drained();

        // Extremes first: saturation with a zero threshold, direct mode with the widest
        // threshold, the smallest screen, a zero span, then the reset values.
        setups.push_back({1'b1, 12'd4095, 12'd4095, 16'd1, 16'd1, 16'd0});
        setups.push_back({1'b0, 12'd1, 12'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        setups.push_back({1'b1, 12'd1, 12'd1, 16'hFFFF, 16'hFFFF, 16'd1});
        setups.push_back({1'b1, 12'd2047, 12'd2730, 16'd0, 16'd3, 16'd5});
        setups.push_back({RST_SCALE_EN, RST_SCR_W, RST_SCR_H, RST_SPAN_X, RST_SPAN_Y,
                          RST_TAP_THR});
        repeat (3) begin
            s.scale  = 1'($urandom_range(0, 1));
            s.width  = LCD_W'($urandom_range(1, 4095));
            s.height = LCD_W'($urandom_range(1, 4095));
            s.span_x = SPAN_W'($urandom_range(1, 65535));
            s.span_y = SPAN_W'($urandom_range(1, 65535));
            s.thr    = ($urandom_range(0, 1) == 0) ? THR_W'($urandom_range(0, 64))
                                                   : THR_W'($urandom_range(0, 65535));
            setups.push_back(s);
        end

        foreach (setups[i]) begin
            apply_setup(setups[i]);
            run_random(180);
            wait_drained();
        end

        if (pending_reports.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_reports.size());
        end
        $display("Sent %0d events (%0d directed) under %0d register setups; %0d results checked.",
                 events_sent, directed_count, setups_applied, reports_checked);
        $display("Gestures seen: none %0d, tap %0d, up %0d, down %0d, left %0d, right %0d.",
                 gesture_hits[G_NONE], gesture_hits[G_TAP], gesture_hits[G_UP],
                 gesture_hits[G_DOWN], gesture_hits[G_LEFT], gesture_hits[G_RIGHT]);
        if (mismatches == 0) begin
            $display("touch_gesture_classifier_unit test passed");
        end else begin
            $display("touch_gesture_classifier_unit test failed");
        end
        $finish;
    end

endmodule
